// ===== rtl/bgd_pkg.sv =====
// shared types and constants of the button gesture detector
package bgd_pkg;

  localparam int NUM_BUTTONS_DEF = 9;
  localparam int TIME_BITS_DEF   = 32;

  localparam int MASK_W    = 9;
  localparam int TIME_IN_W = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int N_OUT     = 11;

  localparam int S_TDATA_W = ((2 * MASK_W + TIME_IN_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((N_OUT * MASK_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST      = CFG_W'(400);
  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RST    = CFG_W'(300);
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = CFG_W'(400);
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = CFG_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS,
    REG_DOUBLE_PRESS,
    REG_REPEAT_DELAY,
    REG_REPEAT_INTERVAL
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic {
    ACT_TICK,
    ACT_RELEASE
  } action_e;

  typedef struct packed {
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] double_ms;
    logic [CFG_W-1:0] delay_ms;
    logic [CFG_W-1:0] interval_ms;
  } cfg_t;

  typedef struct packed {
    logic eval;
    logic clear;
    logic cur;
    logic prev;
  } lane_ctrl_t;

  typedef struct packed {
    logic long_hit;
    logic rep_req;
    logic dbl_hit;
  } lane_flags_t;

  typedef struct packed {
    logic             neg;
    logic [CFG_W-1:0] mag;
  } rem_t;

endpackage

// ===== rtl/bgd_lane.sv =====
// per-button lane: press and release stamps and the hold and gap compares
module bgd_lane #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bgd_pkg::lane_ctrl_t  ctrl_i,
  input  bgd_pkg::cfg_t        cfg_i,
  input  logic [TIME_BITS-1:0] now_i,
  output bgd_pkg::lane_flags_t flags_o
);
  import bgd_pkg::*;

  localparam int CW = TIME_BITS + 2;

  logic [TIME_BITS-1:0] press_q, press_d, rel_q, rel_d;
  logic                 press_vld_q, press_vld_d, rel_vld_q, rel_vld_d;
  logic [TIME_BITS-1:0] held, gap, gap_before;
  logic signed [CW-1:0] held_e, gap_e, before_e, long_e, delay_e, double_e;
  logic                 hold_path, press_edge, rel_edge;

  assign held       = now_i - press_q;
  assign gap        = now_i - rel_q;
  assign gap_before = rel_q - press_q;

  assign held_e   = {{2{held[TIME_BITS-1]}}, held};
  assign gap_e    = {{2{gap[TIME_BITS-1]}}, gap};
  assign before_e = {{2{gap_before[TIME_BITS-1]}}, gap_before};
  assign long_e   = {{(CW-CFG_W){1'b0}}, cfg_i.long_ms};
  assign delay_e  = {{(CW-CFG_W){1'b0}}, cfg_i.delay_ms};
  assign double_e = {{(CW-CFG_W){1'b0}}, cfg_i.double_ms};

  assign hold_path  = ctrl_i.cur & ctrl_i.prev;
  assign press_edge = ctrl_i.cur & ~ctrl_i.prev;
  assign rel_edge   = ~ctrl_i.cur & ctrl_i.prev;

  assign flags_o.long_hit = hold_path & (held_e >= long_e);
  assign flags_o.rep_req  = hold_path & (held_e >= delay_e);
  assign flags_o.dbl_hit  = press_edge & press_vld_q & rel_vld_q &
                            (gap_e <= double_e) & (before_e <= long_e);

  always_comb begin
    press_d     = press_q;
    press_vld_d = press_vld_q;
    rel_d       = rel_q;
    rel_vld_d   = rel_vld_q;
    if (ctrl_i.clear) begin
      press_d     = '0;
      press_vld_d = 1'b0;
      rel_d       = '0;
      rel_vld_d   = 1'b0;
    end else if (ctrl_i.eval) begin
      if (press_edge) begin
        press_d     = now_i;
        press_vld_d = 1'b1;
      end else if (rel_edge) begin
        rel_d     = now_i;
        rel_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= '0;
      press_vld_q <= 1'b0;
      rel_q       <= '0;
      rel_vld_q   <= 1'b0;
    end else begin
      press_q     <= press_d;
      press_vld_q <= press_vld_d;
      rel_q       <= rel_d;
      rel_vld_q   <= rel_vld_d;
    end
  end

endmodule

// ===== rtl/bgd_rem.sv =====
// bit-serial signed remainder of the autorepeat phase by the repeat interval
module bgd_rem #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [TIME_BITS-1:0]        dividend_i,
  input  logic [bgd_pkg::CFG_W-1:0]   divisor_i,
  output logic                        done_o,
  output bgd_pkg::rem_t               rem_o
);
  import bgd_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] mag_q, mag_d;
  logic [CFG_W-1:0]     part_q, part_d, div_q, div_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CFG_W:0]       trial;

  assign trial = {part_q, mag_q[TIME_BITS-1]};

  always_comb begin
    mag_d  = mag_q;
    part_d = part_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      neg_d  = dividend_i[TIME_BITS-1];
      mag_d  = dividend_i[TIME_BITS-1] ? (~dividend_i + 1'b1) : dividend_i;
      part_d = '0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[TIME_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        part_d = CFG_W'(trial - {1'b0, div_q});
      end else begin
        part_d = trial[CFG_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(TIME_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    part_q <= part_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
  end

  assign done_o    = done_q;
  assign rem_o.neg = neg_q;
  assign rem_o.mag = part_q;

endmodule

// ===== rtl/button_gesture_detector_top.sv =====
// top level of the button gesture detector: control, lanes and merge
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser action, tdata sample
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata eleven gesture masks
//  cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// a tick word passes through ST_LANE, ST_DIV (the bit-serial remainder for the
// autorepeat phase), ST_FIN and ST_OUT; a release word goes straight to ST_OUT
// one word is worked on at a time; the result register lets the next word in
// while the last result waits, and a stalled result holds the block before
// loading the next one
// reset is asynchronous, needs no clearing pass; config is always ready
module button_gesture_detector_top #(
  parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bgd_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // raw_pressed, now_ms, release_mask
  input  logic [bgd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pressed, just_pressed, just_released, long_held, just_long, short_release,
  // long_release, double_held, just_double, double_release, repeat_pulse
  output logic [bgd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bgd_pkg::CFG_W-1:0]        cfg_data_i
);
  import bgd_pkg::*;

  localparam int NB = NUM_BUTTONS;
  localparam int CW = TIME_BITS + 2;

  state_e state_q, state_d;
  logic   s_acc, lane_eval, div_start, fin_load, out_load;

  cfg_t cfg_q;

  logic [MASK_W-1:0]    raw_w, rmask_w;
  logic [TIME_IN_W-1:0] now_w;
  logic [TIME_BITS-1:0] now_t;
  logic [NB-1:0]        raw_b, rmask_b;

  logic [NB-1:0] cur_q, prev_q, long_q, prev_long_q, double_q, repeat_q, forced_q;
  logic [NB-1:0] rep_req_q;
  logic [NB-1:0] forced_tick, cur_tick;
  logic [NB-1:0] long_hits, rep_hits, dbl_hits;
  logic [TIME_BITS-1:0] now_q, last_q, base_q, tick_q, base_eff, phase;
  logic                 last_vld_q, base_vld_q;

  lane_ctrl_t  lane_ctrl [NB];
  lane_flags_t lane_flags [NB];

  logic [CFG_W-1:0] interval_eff;
  logic             div_done;
  rem_t             rem;
  logic signed [CW-1:0] rem_s, tick_s;
  logic             rem_lt;

  logic [NB-1:0]     rel_b;
  logic [NB-1:0]     res_b [N_OUT];
  logic [MASK_W-1:0] res_o [N_OUT];
  logic [M_TDATA_W-1:0] out_word, out_data_q;
  logic              out_valid_q;

  // input unpacking
  assign raw_w   = s_axis_tdata[MASK_W-1:0];
  assign now_w   = s_axis_tdata[MASK_W +: TIME_IN_W];
  assign rmask_w = s_axis_tdata[MASK_W+TIME_IN_W +: MASK_W];
  assign now_t   = now_w[TIME_BITS-1:0];

  for (genvar g = 0; g < NB; g++) begin : g_in
    if (g < MASK_W) begin : g_map
      assign raw_b[g]   = raw_w[g];
      assign rmask_b[g] = rmask_w[g];
    end else begin : g_pad
      assign raw_b[g]   = 1'b0;
      assign rmask_b[g] = 1'b0;
    end
  end

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ms     <= LONG_PRESS_RST;
      cfg_q.double_ms   <= DOUBLE_PRESS_RST;
      cfg_q.delay_ms    <= REPEAT_DELAY_RST;
      cfg_q.interval_ms <= REPEAT_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LONG_PRESS:      cfg_q.long_ms     <= cfg_data_i;
        REG_DOUBLE_PRESS:    cfg_q.double_ms   <= cfg_data_i;
        REG_REPEAT_DELAY:    cfg_q.delay_ms    <= cfg_data_i;
        REG_REPEAT_INTERVAL: cfg_q.interval_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    lane_eval     = 1'b0;
    div_start     = 1'b0;
    fin_load      = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (action_e'(s_axis_tuser) == ACT_RELEASE) ? ST_OUT : ST_LANE;
        end
      end
      ST_LANE: begin
        lane_eval = 1'b1;
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        fin_load = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_acc = s_axis_tvalid & s_axis_tready;

  // lanes
  for (genvar g = 0; g < NB; g++) begin : g_lane
    assign lane_ctrl[g].eval  = lane_eval;
    assign lane_ctrl[g].clear = s_acc & (action_e'(s_axis_tuser) == ACT_RELEASE) & rmask_b[g];
    assign lane_ctrl[g].cur   = cur_q[g];
    assign lane_ctrl[g].prev  = prev_q[g];

    bgd_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl[g]),
      .cfg_i   (cfg_q),
      .now_i   (now_q),
      .flags_o (lane_flags[g])
    );

    assign long_hits[g] = lane_flags[g].long_hit;
    assign rep_hits[g]  = lane_flags[g].rep_req;
    assign dbl_hits[g]  = lane_flags[g].dbl_hit;
  end

  // autorepeat phase against the shared base
  assign base_eff     = base_vld_q ? base_q : now_q;
  assign phase        = now_q - base_eff;
  assign interval_eff = (cfg_q.interval_ms == '0) ? CFG_W'(1) : cfg_q.interval_ms;

  bgd_rem #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (phase),
    .divisor_i  (interval_eff),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign rem_s  = rem.neg ? -$signed({{(CW-CFG_W){1'b0}}, rem.mag})
                          :  $signed({{(CW-CFG_W){1'b0}}, rem.mag});
  assign tick_s = {{2{tick_q[TIME_BITS-1]}}, tick_q};
  assign rem_lt = rem_s < tick_s;

  // state update and merge
  assign forced_tick = forced_q & raw_b;
  assign cur_tick    = raw_b & ~forced_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      prev_q      <= '0;
      long_q      <= '0;
      prev_long_q <= '0;
      double_q    <= '0;
      repeat_q    <= '0;
      forced_q    <= '1;
      rep_req_q   <= '0;
      last_q      <= '0;
      last_vld_q  <= 1'b0;
      base_q      <= '0;
      base_vld_q  <= 1'b0;
      tick_q      <= '0;
      now_q       <= '0;
    end else if (s_acc && action_e'(s_axis_tuser) == ACT_RELEASE) begin
      cur_q       <= cur_q & ~rmask_b;
      long_q      <= long_q & ~rmask_b;
      double_q    <= double_q & ~rmask_b;
      repeat_q    <= repeat_q & ~rmask_b;
      prev_q      <= prev_q & ~rmask_b;
      prev_long_q <= prev_long_q & ~rmask_b;
      forced_q    <= forced_q | rmask_b;
    end else if (s_acc) begin
      double_q    <= double_q & cur_q;
      prev_q      <= cur_q;
      prev_long_q <= long_q;
      forced_q    <= forced_tick;
      cur_q       <= cur_tick;
      long_q      <= long_q & cur_tick;
      repeat_q    <= '0;
      if (cur_tick == '0) begin
        base_vld_q <= 1'b0;
      end
      tick_q     <= last_vld_q ? (now_t - last_q) : '0;
      last_q     <= now_t;
      last_vld_q <= 1'b1;
      now_q      <= now_t;
    end else if (lane_eval) begin
      long_q    <= long_q | long_hits;
      double_q  <= double_q | dbl_hits;
      rep_req_q <= rep_hits;
      if (rep_hits != '0) begin
        base_q     <= base_eff;
        base_vld_q <= 1'b1;
      end
    end else if (fin_load) begin
      repeat_q <= (cur_q & ~prev_q) | (rep_req_q & {NB{rem_lt}});
    end
  end

  // result masks
  assign rel_b = ~cur_q & prev_q;

  always_comb begin
    res_b[0]  = cur_q;
    res_b[1]  = cur_q & ~prev_q;
    res_b[2]  = rel_b;
    res_b[3]  = long_q;
    res_b[4]  = long_q & ~prev_long_q;
    res_b[5]  = rel_b & ~prev_long_q;
    res_b[6]  = rel_b & prev_long_q;
    res_b[7]  = double_q;
    res_b[8]  = double_q & ~prev_q;
    res_b[9]  = rel_b & double_q;
    res_b[10] = repeat_q;
  end

  for (genvar f = 0; f < N_OUT; f++) begin : g_res
    for (genvar g = 0; g < MASK_W; g++) begin : g_bit
      if (g < NB) begin : g_map
        assign res_o[f][g] = res_b[f][g];
      end else begin : g_pad
        assign res_o[f][g] = 1'b0;
      end
    end
  end

  always_comb begin
    out_word = '0;
    for (int f = 0; f < N_OUT; f++) begin
      out_word[f*MASK_W +: MASK_W] = res_o[f];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/bgd_checker.sv =====
// port-level checks of the button gesture detector and their bind
module bgd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bgd_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import bgd_pkg::*;

  logic [MASK_W-1:0] pressed, just_pressed, just_released, long_held;
  logic [MASK_W-1:0] short_rel, long_rel, just_double;

  assign pressed       = m_axis_tdata[0*MASK_W +: MASK_W];
  assign just_pressed  = m_axis_tdata[1*MASK_W +: MASK_W];
  assign just_released = m_axis_tdata[2*MASK_W +: MASK_W];
  assign long_held     = m_axis_tdata[3*MASK_W +: MASK_W];
  assign short_rel     = m_axis_tdata[5*MASK_W +: MASK_W];
  assign long_rel      = m_axis_tdata[6*MASK_W +: MASK_W];
  assign just_double   = m_axis_tdata[8*MASK_W +: MASK_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  a_release_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((short_rel | long_rel) == just_released) &&
                      ((short_rel & long_rel) == '0) &&
                      ((pressed & just_released) == '0))
    else $error("release masks inconsistent");

  a_subsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((just_double & ~just_pressed) == '0) &&
                      ((long_held & ~pressed) == '0) &&
                      ((just_pressed & ~pressed) == '0))
    else $error("gesture mask outside its parent mask");

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (.*);
